// ===== design/run_insertion_merge_sorter_top_assert.svh =====
// Assertion macros for the run insertion merge sorter.
`ifndef RUN_INSERTION_MERGE_SORTER_TOP_ASSERT_SVH
`define RUN_INSERTION_MERGE_SORTER_TOP_ASSERT_SVH

// Check that the consequent holds whenever the antecedent holds.
`define RIMS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rims assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define RIMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rims assertion failed");

`endif

// ===== design/rims_pkg.sv =====
// Shared types for the run insertion merge sorter.
package rims_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RUN,
      ST_INS_RD,
      ST_INS_KEY,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_PASS,
      ST_BLK,
      ST_MRG_RDB,
      ST_MRG_LDB,
      ST_MRG_CMP,
      ST_MRG_FILL,
      ST_CPY_RD,
      ST_CPY_WR
   } state_type;

   typedef struct packed {
      logic wr;
      logic start;
   } ctl_type;

endpackage

// ===== design/rims_if.sv =====
// Request and response channel interfaces.
interface rims_req_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic signed [rims_pkg::DATA_W-1:0] value;
   logic                              last;
   modport source (output valid, output kind, output value, output last, input ready);
   modport sink (input valid, input kind, input value, input last, output ready);
endinterface

interface rims_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rims_pkg::DATA_W-1:0] sorted_value;
   logic                              final_res;
   logic                              empty_res;
   modport source (output valid, output sorted_value, output final_res, output empty_res,
                   input ready);
   modport sink (input valid, input sorted_value, input final_res, input empty_res,
                 output ready);
endinterface

// ===== design/rims_core.sv =====
// Element and scratch memories with the run insertion and merge sequencer.
module rims_core #(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned RUN_LENGTH   = 32,
   localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rims_pkg::ctl_type           ctl,
   input  logic [CW-1:0]               n,
   input  logic [AW-1:0]               wr_addr,
   input  logic [rims_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [rims_pkg::DATA_W-1:0] rd_data,
   output logic                        busy
);

   localparam int unsigned RW = $clog2(RUN_LENGTH + 1);
   localparam int unsigned LW = ((AW > RW) ? AW : RW) + 3;
   localparam logic [LW-1:0] RUN_L = LW'(RUN_LENGTH);

   logic [rims_pkg::DATA_W-1:0] store_mem [MAX_ELEMENTS];
   logic [rims_pkg::DATA_W-1:0] buf_mem [MAX_ELEMENTS];

   rims_pkg::state_type state_ff, state_in;
   logic [LW-1:0] n_ff, n_in, lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, wid_ff, wid_in;
   logic [LW-1:0] i_ff, i_in, j_ff, j_in, a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic [rims_pkg::DATA_W-1:0] key_ff, key_in, va_ff, va_in, vb_ff, vb_in;
   logic side_ff, side_in;
   logic [rims_pkg::DATA_W-1:0] store_rd_ff, buf_rd_ff;

   logic                        store_we, buf_we;
   logic [AW-1:0]               store_waddr, store_raddr, buf_waddr, buf_raddr;
   logic [rims_pkg::DATA_W-1:0] store_wdata, buf_wdata;

   logic [LW-1:0] n_last, run_end, blk_mid, blk_end;
   logic          shift_gt, take_a;

   assign n_last   = n_ff - LW'(1);
   assign run_end  = lo_ff + RUN_L - LW'(1);
   assign blk_mid  = lo_ff + wid_ff - LW'(1);
   assign blk_end  = lo_ff + (wid_ff << 1) - LW'(1);
   assign shift_gt = $signed(store_rd_ff) > $signed(key_ff);
   assign take_a   = (a_ff <= mid_ff) && ((b_ff > hi_ff) || ($signed(va_ff) <= $signed(vb_ff)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rims_pkg::ST_IDLE:     if (ctl.start) state_in = rims_pkg::ST_RUN;
         rims_pkg::ST_RUN:      state_in = (lo_ff < n_ff) ? rims_pkg::ST_INS_RD : rims_pkg::ST_PASS;
         rims_pkg::ST_INS_RD:   state_in = (i_ff > hi_ff) ? rims_pkg::ST_RUN : rims_pkg::ST_INS_KEY;
         rims_pkg::ST_INS_KEY:  state_in = rims_pkg::ST_INS_CMP;
         rims_pkg::ST_INS_CMP: begin
            if (!shift_gt) state_in = rims_pkg::ST_INS_RD;
            else if (j_ff - LW'(1) == lo_ff) state_in = rims_pkg::ST_INS_PUT;
         end
         rims_pkg::ST_INS_PUT:  state_in = rims_pkg::ST_INS_RD;
         rims_pkg::ST_PASS:     state_in = (wid_ff < n_ff) ? rims_pkg::ST_BLK : rims_pkg::ST_IDLE;
         rims_pkg::ST_BLK: begin
            if (lo_ff >= n_ff) state_in = rims_pkg::ST_PASS;
            else if (blk_mid < n_last) state_in = rims_pkg::ST_MRG_RDB;
         end
         rims_pkg::ST_MRG_RDB:  state_in = rims_pkg::ST_MRG_LDB;
         rims_pkg::ST_MRG_LDB:  state_in = rims_pkg::ST_MRG_CMP;
         rims_pkg::ST_MRG_CMP:
            state_in = (k_ff > hi_ff) ? rims_pkg::ST_CPY_RD : rims_pkg::ST_MRG_FILL;
         rims_pkg::ST_MRG_FILL: state_in = rims_pkg::ST_MRG_CMP;
         rims_pkg::ST_CPY_RD:   state_in = rims_pkg::ST_CPY_WR;
         rims_pkg::ST_CPY_WR:
            state_in = (k_ff == hi_ff) ? rims_pkg::ST_BLK : rims_pkg::ST_CPY_RD;
         default:               state_in = rims_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      n_in = n_ff; lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff; wid_in = wid_ff;
      i_in = i_ff; j_in = j_ff; a_in = a_ff; b_in = b_ff; k_in = k_ff;
      key_in = key_ff; va_in = va_ff; vb_in = vb_ff; side_in = side_ff;
      store_we = 1'b0; store_waddr = wr_addr; store_wdata = wr_data; store_raddr = rd_addr;
      buf_we = 1'b0; buf_waddr = k_ff[AW-1:0]; buf_wdata = va_ff; buf_raddr = k_ff[AW-1:0];
      unique case (state_ff)
         rims_pkg::ST_IDLE: begin
            store_we = ctl.wr;
            if (ctl.start) begin
               n_in  = LW'(n);
               lo_in = '0;
            end
         end
         rims_pkg::ST_RUN: begin
            if (lo_ff < n_ff) begin
               hi_in = (run_end > n_last) ? n_last : run_end;
               i_in  = lo_ff + LW'(1);
            end else begin
               wid_in = RUN_L;
            end
         end
         rims_pkg::ST_INS_RD: begin
            store_raddr = i_ff[AW-1:0];
            if (i_ff > hi_ff) lo_in = lo_ff + RUN_L;
         end
         rims_pkg::ST_INS_KEY: begin
            key_in      = store_rd_ff;
            j_in        = i_ff;
            store_raddr = AW'(i_ff - LW'(1));
         end
         rims_pkg::ST_INS_CMP: begin
            store_we    = 1'b1;
            store_waddr = j_ff[AW-1:0];
            store_raddr = AW'(j_ff - LW'(2));
            if (shift_gt) begin
               store_wdata = store_rd_ff;
               j_in        = j_ff - LW'(1);
            end else begin
               store_wdata = key_ff;
               i_in        = i_ff + LW'(1);
            end
         end
         rims_pkg::ST_INS_PUT: begin
            store_we    = 1'b1;
            store_waddr = j_ff[AW-1:0];
            store_wdata = key_ff;
            i_in        = i_ff + LW'(1);
         end
         rims_pkg::ST_PASS: lo_in = '0;
         rims_pkg::ST_BLK: begin
            store_raddr = lo_ff[AW-1:0];
            if (lo_ff >= n_ff) begin
               wid_in = wid_ff << 1;
            end else if (blk_mid >= n_last) begin
               lo_in = lo_ff + (wid_ff << 1);
            end else begin
               mid_in = blk_mid;
               hi_in  = (blk_end > n_last) ? n_last : blk_end;
               a_in   = lo_ff;
               b_in   = lo_ff + wid_ff;
               k_in   = lo_ff;
            end
         end
         rims_pkg::ST_MRG_RDB: begin
            va_in       = store_rd_ff;
            store_raddr = b_ff[AW-1:0];
         end
         rims_pkg::ST_MRG_LDB: vb_in = store_rd_ff;
         rims_pkg::ST_MRG_CMP: begin
            if (k_ff > hi_ff) begin
               k_in = lo_ff;
            end else begin
               buf_we    = 1'b1;
               buf_wdata = take_a ? va_ff : vb_ff;
               k_in      = k_ff + LW'(1);
               side_in   = take_a;
               if (take_a) begin
                  a_in        = a_ff + LW'(1);
                  store_raddr = AW'(a_ff + LW'(1));
               end else begin
                  b_in        = b_ff + LW'(1);
                  store_raddr = AW'(b_ff + LW'(1));
               end
            end
         end
         rims_pkg::ST_MRG_FILL: begin
            if (side_ff) va_in = store_rd_ff;
            else vb_in = store_rd_ff;
         end
         rims_pkg::ST_CPY_RD: buf_raddr = k_ff[AW-1:0];
         rims_pkg::ST_CPY_WR: begin
            store_we    = 1'b1;
            store_waddr = k_ff[AW-1:0];
            store_wdata = buf_rd_ff;
            if (k_ff == hi_ff) lo_in = lo_ff + (wid_ff << 1);
            else k_in = k_ff + LW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rims_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in; wid_ff <= wid_in;
      i_ff <= i_in; j_ff <= j_in; a_ff <= a_in; b_ff <= b_in; k_ff <= k_in;
      key_ff <= key_in; va_ff <= va_in; vb_ff <= vb_in; side_ff <= side_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_waddr] <= store_wdata;
      store_rd_ff <= store_mem[store_raddr];
   end

   always_ff @(posedge clock) begin
      if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
      buf_rd_ff <= buf_mem[buf_raddr];
   end

   assign rd_data = store_rd_ff;
   assign busy    = (state_ff != rims_pkg::ST_IDLE);

endmodule

// ===== design/run_insertion_merge_sorter_top.sv =====
// Top level of the run insertion merge sorter.
// A load request is written to the element memory as it is taken, if there is room; a fetch
// response passes through the pending register and then the response register, and the next
// request is taken once no fetch is pending and that register is free. After a load marked
// last the block takes no request until the sort ends: each element of a run is read, taken
// as the key and compared per shift, and each merge pass merges each element into the scratch
// memory and copies it back, all set by the single read port of each memory.
`include "run_insertion_merge_sorter_top_assert.svh"
module run_insertion_merge_sorter_top #(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned RUN_LENGTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   rims_req_if.sink    req_chan,
   rims_rsp_if.source  rsp_chan
);

   localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

   logic [CW-1:0] count_ff, count_in, rp_ff, rp_in, count_eff;
   logic          sorted_ff, sorted_in, pend_ff, pend_in, pend_hit_ff, pend_hit_in;
   logic          pend_final_ff, pend_final_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_final_ff, rsp_final_in;
   logic          rsp_empty_ff, rsp_empty_in;
   logic [rims_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in, core_rd;
   logic          req_acc, load_acc, fetch_acc, room, hit, busy;
   rims_pkg::ctl_type ctl;

   assign req_acc   = req_chan.valid && req_chan.ready;
   assign load_acc  = req_acc && !req_chan.kind;
   assign fetch_acc = req_acc && req_chan.kind;
   assign count_eff = sorted_ff ? '0 : count_ff;
   assign room      = count_eff < CW'(MAX_ELEMENTS);
   assign hit       = sorted_ff && (rp_ff < count_ff);

   assign req_chan.ready = !busy && !pend_ff && (!rsp_valid_ff || rsp_chan.ready);

   assign ctl.wr    = load_acc && room;
   assign ctl.start = load_acc && req_chan.last;

   always_comb begin
      count_in = count_ff;
      sorted_in = sorted_ff;
      rp_in = rp_ff;
      if (load_acc) begin
         count_in  = room ? count_eff + CW'(1) : count_eff;
         sorted_in = req_chan.last;
         rp_in     = '0;
      end else if (fetch_acc && hit) begin
         rp_in = rp_ff + CW'(1);
      end
   end

   assign pend_in       = fetch_acc;
   assign pend_hit_in   = hit;
   assign pend_final_in = (rp_ff + CW'(1)) == count_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      rsp_empty_in = rsp_empty_ff;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = pend_hit_ff ? core_rd : '0;
         rsp_final_in = pend_hit_ff && pend_final_ff;
         rsp_empty_in = !pend_hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rp_ff        <= '0;
         sorted_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         sorted_ff    <= sorted_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_hit_ff   <= pend_hit_in;
      pend_final_ff <= pend_final_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_final_ff  <= rsp_final_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   rims_core #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .RUN_LENGTH   (RUN_LENGTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .n       (count_in),
      .wr_addr (count_eff[AW-1:0]),
      .wr_data (req_chan.value),
      .rd_addr (rp_ff[AW-1:0]),
      .rd_data (core_rd),
      .busy    (busy)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = rsp_value_ff;
   assign rsp_chan.final_res    = rsp_final_ff;
   assign rsp_chan.empty_res    = rsp_empty_ff;

   `RIMS_ASSERT_IMPL(a_fetch_resp, clock, reset, fetch_acc, ##2 rsp_valid_ff)
   `RIMS_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(MAX_ELEMENTS))
   `RIMS_ASSERT_IMPL(a_rp_bound, clock, reset, sorted_ff && !busy, rp_ff <= count_ff)
   `RIMS_ASSERT_NEXT(a_sort_busy, clock, reset, ctl.start, busy && sorted_ff)

endmodule

// ===== test/rims_tb_pkg.sv =====
// Request row type shared by the sorter testbench.
package rims_tb_pkg;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_FETCH = 1'b1
   } req_kind_type;

   typedef struct {
      req_kind_type      kind;
      logic signed [31:0] value;
      logic              last;
      logic              chk;
      logic signed [31:0] exp_value;
      logic              exp_final;
      logic              exp_empty;
   } req_row_type;

endpackage

// ===== test/tb_run_insertion_merge_sorter_top.sv =====
// Testbench for the run insertion merge sorter: directed table, then random data sets.
module tb_run_insertion_merge_sorter_top;

   localparam int unsigned CAPACITY = 1024;
   localparam int unsigned RUN_LEN  = 32;

   typedef struct {
      logic signed [31:0] value;
      logic              final_res;
      logic              empty_res;
   } sorted_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rims_req_if req_chan ();
   rims_rsp_if rsp_chan ();

   run_insertion_merge_sorter_top #(
      .MAX_ELEMENTS(CAPACITY),
      .RUN_LENGTH  (RUN_LEN)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200000000;
      $display("Test completed with failures");
      $finish;
   end

   logic signed [31:0] store_words [CAPACITY];
   int unsigned        stored_count = 0;
   int unsigned        fetch_index  = 0;
   bit                 sorted_flag  = 0;
   sorted_word_type    pending_words [$];
   int                 mismatches   = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;

   function automatic void sort_stored();
      logic signed [31:0] key;
      logic signed [31:0] scratch [CAPACITY];
      int unsigned lo, hi, j, mid, width, a, b, k;
      if (stored_count == 0) return;
      for (lo = 0; lo < stored_count; lo += RUN_LEN) begin
         hi = lo + RUN_LEN - 1;
         if (hi > stored_count - 1) hi = stored_count - 1;
         for (int unsigned i = lo + 1; i <= hi; i++) begin
            key = store_words[i];
            j = i;
            while (j > lo && store_words[j-1] > key) begin
               store_words[j] = store_words[j-1];
               j--;
            end
            store_words[j] = key;
         end
      end
      for (width = RUN_LEN; width < stored_count; width *= 2) begin
         for (lo = 0; lo < stored_count; lo += 2 * width) begin
            mid = lo + width - 1;
            hi  = lo + 2 * width - 1;
            if (mid >= stored_count - 1) continue;
            if (hi > stored_count - 1) hi = stored_count - 1;
            a = lo; b = mid + 1; k = lo;
            while (a <= mid && b <= hi) begin
               if (store_words[a] <= store_words[b]) scratch[k++] = store_words[a++];
               else scratch[k++] = store_words[b++];
            end
            while (a <= mid) scratch[k++] = store_words[a++];
            while (b <= hi) scratch[k++] = store_words[b++];
            for (k = lo; k <= hi; k++) store_words[k] = scratch[k];
         end
      end
   endfunction

   function automatic void predict_request(rims_tb_pkg::req_row_type r);
      sorted_word_type w;
      if (r.kind == rims_tb_pkg::KIND_LOAD) begin
         if (sorted_flag) begin
            sorted_flag = 0;
            stored_count = 0;
            fetch_index = 0;
         end
         if (stored_count < CAPACITY) store_words[stored_count++] = r.value;
         if (r.last) begin
            sort_stored();
            sorted_flag = 1;
            fetch_index = 0;
         end
         return;
      end
      if (sorted_flag && fetch_index < stored_count) begin
         w.value = store_words[fetch_index];
         w.final_res = (fetch_index + 1 == stored_count);
         w.empty_res = 0;
         fetch_index++;
      end else begin
         w.value = '0; w.final_res = 0; w.empty_res = 1;
      end
      if (r.chk && (w.value !== r.exp_value || w.final_res !== r.exp_final
                    || w.empty_res !== r.exp_empty)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed row: expected %0d/%b/%b, predicted %0d/%b/%b", r.exp_value,
                     r.exp_final, r.exp_empty, w.value, w.final_res, w.empty_res);
      end
      pending_words.push_back(w);
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind  = 1'b0;
      req_chan.value = '0;
      req_chan.last  = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      sorted_word_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %0d", rsp_chan.sorted_value);
         end else begin
            w = pending_words.pop_front();
            if (rsp_chan.sorted_value !== w.value || rsp_chan.final_res !== w.final_res
                || rsp_chan.empty_res !== w.empty_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%b/%b, got %0d/%b/%b", w.value,
                           w.final_res, w.empty_res, rsp_chan.sorted_value,
                           rsp_chan.final_res, rsp_chan.empty_res);
            end
         end
      end
   end

   task automatic send_request(rims_tb_pkg::req_row_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind  <= r.kind;
      req_chan.value <= r.value;
      req_chan.last  <= r.last;
      do @(posedge clock); while (!req_chan.ready);
      predict_request(r);
   endtask

   function automatic rims_tb_pkg::req_row_type make_row(rims_tb_pkg::req_kind_type kind,
                                                         logic signed [31:0] value,
                                                         logic last);
      rims_tb_pkg::req_row_type r;
      r.kind = kind; r.value = value; r.last = last;
      r.chk = 0; r.exp_value = '0; r.exp_final = 0; r.exp_empty = 0;
      return r;
   endfunction

   function automatic rims_tb_pkg::req_row_type make_checked(logic signed [31:0] v, logic f,
                                                             logic e);
      rims_tb_pkg::req_row_type r;
      r = make_row(rims_tb_pkg::KIND_FETCH, $urandom, 1'($urandom_range(1)));
      r.chk = 1; r.exp_value = v; r.exp_final = f; r.exp_empty = e;
      return r;
   endfunction

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed(32'($urandom_range(7))) - 3;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_data_set(int unsigned n, int unsigned fetches);
      for (int unsigned i = 0; i < n; i++)
         send_request(make_row(rims_tb_pkg::KIND_LOAD, random_value(), i == n - 1));
      for (int unsigned i = 0; i < fetches; i++)
         send_request(make_row(rims_tb_pkg::KIND_FETCH, $urandom, 1'($urandom_range(1))));
   endtask

   initial begin
      rims_tb_pkg::req_row_type table_rows [$];
      int unsigned n;
      table_rows = '{
         make_checked(32'sd0, 1'b0, 1'b1),
         make_row(rims_tb_pkg::KIND_LOAD, 32'sh7fff_ffff, 1'b0),
         make_row(rims_tb_pkg::KIND_LOAD, 32'sh8000_0000, 1'b0),
         make_row(rims_tb_pkg::KIND_LOAD, -32'sd1, 1'b0),
         make_row(rims_tb_pkg::KIND_LOAD, 32'sd0, 1'b1),
         make_checked(32'sh8000_0000, 1'b0, 1'b0),
         make_checked(-32'sd1, 1'b0, 1'b0),
         make_checked(32'sd0, 1'b0, 1'b0),
         make_checked(32'sh7fff_ffff, 1'b1, 1'b0),
         make_checked(32'sd0, 1'b0, 1'b1),
         make_checked(32'sd0, 1'b0, 1'b1),
         make_row(rims_tb_pkg::KIND_LOAD, 32'sd5, 1'b1),
         make_checked(32'sd5, 1'b1, 1'b0),
         make_checked(32'sd0, 1'b0, 1'b1),
         make_row(rims_tb_pkg::KIND_LOAD, 32'sd9, 1'b0),
         make_checked(32'sd0, 1'b0, 1'b1),
         make_row(rims_tb_pkg::KIND_LOAD, 32'sd9, 1'b0),
         make_row(rims_tb_pkg::KIND_LOAD, 32'sd3, 1'b1),
         make_checked(32'sd3, 1'b0, 1'b0),
         make_checked(32'sd9, 1'b0, 1'b0),
         make_checked(32'sd9, 1'b1, 1'b0)
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 17; recv_idle_pct = 49;
      foreach (table_rows[i]) send_request(table_rows[i]);
      // run boundaries, one skipped merge and a full store with drops
      send_data_set(33, 35);
      send_data_set(65, 66);
      send_data_set(CAPACITY + 3, 20);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 17 : 0;
         for (int s = 0; s < 2; s++) begin
            n = $urandom_range(1, 12);
            if ($urandom_range(5) == 0)
               send_request(make_row(rims_tb_pkg::KIND_FETCH, $urandom,
                                     1'($urandom_range(1))));
            send_data_set(n, n + $urandom_range(2));
         end
      end
      req_chan.valid <= 1'b0;
      n = 0;
      while (pending_words.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
